FILE: rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on a given clock and active-low reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Assert a property on the standard clk_i / rst_ni pair.
`define ASSERT_STD(label, prop, msg) `ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/ghist_pkg.sv
// Types and constants of the gray-level histogram.
package ghist_pkg;

  localparam int unsigned NumBins      = 256;
  localparam int unsigned MaxPixels    = 1048576;
  localparam int unsigned CountW       = 21;
  localparam int unsigned ValueW       = 8;
  localparam logic [ValueW-1:0] MaxGrayReset = 8'hFF;

  typedef enum logic {
    OP_COUNT = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2
  } status_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EXEC = 1'b1
  } back_state_e;

  typedef struct packed {
    op_e               op;
    logic [ValueW-1:0] value;
  } in_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    status_e           status;
  } out_t;

  typedef struct packed {
    op_e               op;
    logic              in_range;
    logic [ValueW-1:0] index;
  } cmd_t;

endpackage

FILE: rtl/gray_level_histogram.sv
// Gray-level histogram: top level joining front end, queue and back end.
//
// Input channel (in_valid_i / in_ready_o / in_i): each transaction carries an
// op and a value. A count op adds one to the bin of the pixel's gray level and
// returns the new count; a read op returns a bin's count and clears the bin.
// Output channel (out_valid_o / out_ready_i / out_o): one result per input,
// in input order, with count and status (ok, out of range, saturated).
// cfg_we_i / cfg_wdata_i write max_gray; write only while the block is idle.
// An input goes into the queue, then into the back end's command register as
// its bin is read, then into the result register. The back end takes no new
// item until the last one's read-modify-write of the bin memory is done.
// A two-entry queue lets the input side keep accepting while the back end
// works; when the receiver stalls, the result register holds, the back end
// stops and the queue fills, then in_ready_o drops.
// Reset: all bins read as zero at once (per-bin valid flags), max_gray is 255,
// and no result is pending.
module gray_level_histogram import ghist_pkg::*; #(
  parameter int unsigned NUM_BINS = NumBins
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ValueW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_t               in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_t              out_o
);

  logic push;
  cmd_t front_cmd;
  logic q_ready;
  logic pop;
  cmd_t q_cmd;
  logic q_valid;

  ghist_front #(
    .NUM_BINS (NUM_BINS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .push_o      (push),
    .cmd_o       (front_cmd),
    .q_ready_i   (q_ready)
  );

  ghist_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .ready_o (q_ready),
    .pop_i   (pop),
    .cmd_o   (q_cmd),
    .valid_o (q_valid)
  );

  ghist_back #(
    .NUM_BINS (NUM_BINS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

FILE: rtl/ghist_ram.sv
// Generic single-port-write, registered-read RAM.
module ghist_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ghist_front.sv
// Front end: max_gray register, input handshake and range classification.
module ghist_front import ghist_pkg::*; #(
  parameter int unsigned NUM_BINS = NumBins
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ValueW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_t               in_i,
  output logic              push_o,
  output cmd_t              cmd_o,
  input  logic              q_ready_i
);

  logic [ValueW-1:0] max_gray_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_gray_q <= MaxGrayReset;
    end else if (cfg_we_i) begin
      max_gray_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i;

  always_comb begin
    cmd_o.op       = in_i.op;
    cmd_o.index    = in_i.value;
    cmd_o.in_range = (in_i.value <= max_gray_q) &&
                     ({1'b0, in_i.value} < (ValueW+1)'(NUM_BINS));
  end

endmodule

FILE: rtl/ghist_fifo.sv
// Two-entry command queue between front and back end.
module ghist_fifo import ghist_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic ready_o,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic valid_o
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

FILE: rtl/ghist_back.sv
// Back end: read-modify-write of the bin store and the result register.
module ghist_back import ghist_pkg::*; #(
  parameter int unsigned NUM_BINS = NumBins
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  input  cmd_t q_cmd_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  localparam int unsigned IdxW = $clog2(NUM_BINS);

  back_state_e         state_q, state_d;
  cmd_t                cmd_q;
  logic [NUM_BINS-1:0] valid_q, valid_d;
  logic                out_valid_q, out_valid_d;
  out_t                out_q, out_d;
  logic [CountW-1:0]   rdata;
  logic [CountW-1:0]   cur;
  logic                we;
  logic [CountW-1:0]   wdata;
  logic [IdxW-1:0]     idx;

  assign idx = cmd_q.index[IdxW-1:0];

  ghist_ram #(
    .Width (CountW),
    .Depth (NUM_BINS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (idx),
    .wdata_i (wdata),
    .raddr_i (q_cmd_i.index[IdxW-1:0]),
    .rdata_o (rdata)
  );

  assign cur = valid_q[idx] ? rdata : '0;

  always_comb begin
    state_d     = state_q;
    pop_o       = 1'b0;
    we          = 1'b0;
    wdata       = '0;
    valid_d     = valid_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i && (!out_valid_q || out_ready_i)) begin
          pop_o   = 1'b1;
          state_d = BK_EXEC;
        end
      end
      BK_EXEC: begin
        state_d     = BK_IDLE;
        out_valid_d = 1'b1;
        if (!cmd_q.in_range) begin
          out_d.count  = '0;
          out_d.status = ST_RANGE;
        end else if (cmd_q.op == OP_COUNT) begin
          if (cur >= CountW'(MaxPixels)) begin
            out_d.count  = CountW'(MaxPixels);
            out_d.status = ST_SAT;
          end else begin
            we           = 1'b1;
            wdata        = cur + CountW'(1);
            valid_d[idx] = 1'b1;
            out_d.count  = cur + CountW'(1);
            out_d.status = ST_OK;
          end
        end else begin
          we           = 1'b1;
          wdata        = '0;
          valid_d[idx] = 1'b1;
          out_d.count  = cur;
          out_d.status = ST_OK;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= q_cmd_i;
    end
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: rtl/ghist_checker.sv
// Port-level checker for the gray-level histogram and its bind.
`include "assert_macros.svh"

module ghist_checker import ghist_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_o
);

  `ASSERT_STD(a_out_hold,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o),
    "result changed while stalled")
  `ASSERT_STD(a_range_zero,
    out_valid_o && out_o.status == ST_RANGE |-> out_o.count == '0,
    "out-of-range result with nonzero count")
  `ASSERT_STD(a_sat_max,
    out_valid_o && out_o.status == ST_SAT |-> out_o.count == CountW'(MaxPixels),
    "saturated result not at bound")
  `ASSERT_STD(a_count_bound,
    out_valid_o |-> out_o.count <= CountW'(MaxPixels),
    "count above bound")

endmodule

bind gray_level_histogram ghist_checker u_checker (.*);

FILE: tb/gray_level_histogram_tb.sv
// Testbench for the gray-level histogram: directed and random traffic with a scoreboard.
`timescale 1ns / 100ps

module gray_level_histogram_tb;
  import ghist_pkg::*;

  localparam int unsigned CycleLimit = 500_000;

  class hist_scoreboard;
    logic [CountW-1:0] tally [NumBins];
    logic [ValueW-1:0] gray_limit;
    out_t              due_results[$];
    int unsigned       errors;

    function new();
      foreach (tally[i]) tally[i] = '0;
      gray_limit = MaxGrayReset;
      errors = 0;
    endfunction

    function void set_limit(logic [ValueW-1:0] v);
      gray_limit = v;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void note_pixel_op(in_t item);
      out_t r;
      r.count  = '0;
      r.status = ST_OK;
      if (item.value > gray_limit || item.value >= NumBins) begin
        r.status = ST_RANGE;
      end else if (item.op == OP_COUNT) begin
        if (tally[item.value] >= MaxPixels) begin
          tally[item.value] = CountW'(MaxPixels);
          r.count  = CountW'(MaxPixels);
          r.status = ST_SAT;
        end else begin
          tally[item.value] = tally[item.value] + 1'b1;
          r.count = tally[item.value];
        end
      end else begin
        r.count = tally[item.value];
        tally[item.value] = '0;
      end
      due_results.push_back(r);
    endfunction

    task report(string what);
      if (errors < 50) $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(out_t got);
      out_t want;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result count=%0d status=%0d", got.count, got.status));
        return;
      end
      want = due_results.pop_front();
      if (got.count !== want.count)
        report($sformatf("count %0d, expected %0d", got.count, want.count));
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
    endtask
  endclass

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [ValueW-1:0] cfg_wdata = '0;
  logic              in_valid  = 1'b0;
  in_t               in_data   = '0;
  logic              in_ready;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_data;

  hist_scoreboard board = new();
  int unsigned    cycles = 0;
  int             stall_left = 0;
  bit             src_steady = 1'b0;
  bit             sink_steady = 1'b0;

  gray_level_histogram DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 75) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!sink_steady && $urandom_range(0, 99) < 25) begin
      stall_left = idle_len() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      if (in_valid && in_ready) board.note_pixel_op(in_data);
      if (out_valid && out_ready) board.check_result(out_data);
    end
  end

  task automatic send_item(op_e op, logic [ValueW-1:0] v);
    in_t t;
    int  gap;
    t.op    = op;
    t.value = v;
    gap = (src_steady || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_gray_limit(logic [ValueW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_limit(v);
  endtask

  task automatic read_out(int top);
    for (int b = 0; b <= top; b++) send_item(OP_READ, ValueW'(b));
  endtask

  initial begin
    int g;
    int hot;
    int pick;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(OP_COUNT, 8'd0);
    send_item(OP_COUNT, 8'd0);
    send_item(OP_COUNT, 8'd255);
    send_item(OP_COUNT, 8'd200);
    send_item(OP_COUNT, 8'd200);
    send_item(OP_READ, 8'd0);
    send_item(OP_READ, 8'd0);
    send_item(OP_READ, 8'd255);
    drain();
    set_gray_limit(8'd100);
    send_item(OP_COUNT, 8'd200);
    send_item(OP_READ, 8'd200);
    send_item(OP_COUNT, 8'd100);
    send_item(OP_COUNT, 8'd101);
    send_item(OP_READ, 8'd100);
    drain();
    set_gray_limit(8'd0);
    send_item(OP_COUNT, 8'd0);
    send_item(OP_COUNT, 8'd1);
    send_item(OP_READ, 8'd0);
    send_item(OP_READ, 8'd255);
    drain();
    set_gray_limit(8'd1);
    send_item(OP_COUNT, 8'd1);
    send_item(OP_COUNT, 8'd2);
    send_item(OP_READ, 8'd1);
    drain();
    set_gray_limit(8'd255);
    send_item(OP_READ, 8'd200);

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: g = 255;
        1: g = 1;
        2: g = 0;
        6: g = 255;
        default: g = $urandom_range(2, 254);
      endcase
      drain();
      set_gray_limit(ValueW'(g));
      for (int n = 0; n < 100; n++) begin
        if (n % 40 == 0) begin
          src_steady  = ($urandom_range(0, 3) == 0);
          sink_steady = ($urandom_range(0, 3) == 0);
          hot = $urandom_range(0, g);
        end
        pick = $urandom_range(0, 99);
        if (pick < 65)
          send_item(OP_COUNT,
                    ValueW'(($urandom_range(0, 2) == 0) ? $urandom_range(0, g) : hot));
        else if (pick < 80)
          send_item(OP_READ, ValueW'($urandom_range(0, g)));
        else
          send_item(op_e'($urandom_range(0, 1)), ValueW'($urandom_range(0, 255)));
      end
      if (g < 64 || $urandom_range(0, 1) == 1) read_out(g);
    end

    drain();
    if (board.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
